@@ rtl/srmp_pkg.sv @@
`default_nettype none

package srmp_pkg;

  // Block parameters
  localparam int MAX_SAMPLES      = 2048;
  localparam int PIXELS_PER_METER = 20;
  localparam int ANGLE_BITS       = 16;

  // Fixed field widths
  localparam int RANGE_W = 16;
  localparam int POS_W   = 32;
  localparam int ANG_W   = 16;
  localparam int SCNT_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Derived widths
  localparam int SEEN_W       = $clog2(MAX_SAMPLES);
  localparam int PHASE_PAD    = 32 - ANGLE_BITS;
  localparam int CORDIC_STEPS = 16;
  localparam int K_W          = $clog2(CORDIC_STEPS);
  localparam int X_W          = RANGE_W + $clog2(PIXELS_PER_METER) + 8 + 3;
  localparam int Z_W          = 32;
  localparam int GB_W         = 25;
  localparam int P_W          = X_W + GB_W;
  localparam int C_W          = P_W - 32;
  localparam int X_SCALE      = PIXELS_PER_METER * 256;
  localparam int GAIN_Q24     = 10187995;

  localparam logic [ANGLE_BITS-1:0] ANG_QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POS_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADING      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_SETUP,
    ST_ROTATE,
    ST_GAIN_X,
    ST_GAIN_Y,
    ST_FINISH
  } srmp_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } srmp_cordic_stat_t;

  // atan(2^-k) in units of 2^-32 turn
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [K_W-1:0] k);
    logic signed [Z_W-1:0] v;
    case (k)
      4'd0:    v = 32'sd536870912;
      4'd1:    v = 32'sd316933406;
      4'd2:    v = 32'sd167458907;
      4'd3:    v = 32'sd85004756;
      4'd4:    v = 32'sd42667331;
      4'd5:    v = 32'sd21354465;
      4'd6:    v = 32'sd10679838;
      4'd7:    v = 32'sd5340245;
      4'd8:    v = 32'sd2670163;
      4'd9:    v = 32'sd1335087;
      4'd10:   v = 32'sd667544;
      4'd11:   v = 32'sd333772;
      4'd12:   v = 32'sd166886;
      4'd13:   v = 32'sd83443;
      4'd14:   v = 32'sd41722;
      default: v = 32'sd20861;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/srmp_cordic.sv @@
`default_nettype none

module srmp_cordic import srmp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [X_W-1:0] x0_i,
  input  logic signed [Z_W-1:0] z0_i,
  output logic signed [X_W-1:0] x_o,
  output logic signed [X_W-1:0] y_o,
  output srmp_cordic_stat_t     stat_o
);

  logic signed [X_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [X_W-1:0] dx, dy;
  logic signed [Z_W-1:0] z_q, z_d;
  logic [K_W-1:0]        k_q, k_d;
  logic                  busy_q, busy_d, done_q, done_d;

  always_comb begin
    dx     = y_q >>> k_q;
    dy     = x_q >>> k_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    k_d    = k_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = x0_i;
      y_d    = '0;
      z_d    = z0_i;
      k_d    = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // rotate toward zero residual angle
      if (!z_q[Z_W-1]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - atan_lut(k_q);
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + atan_lut(k_q);
      end
      k_d = k_q + K_W'(1);
      if (k_q == K_W'(CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      k_q    <= k_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o         = x_q;
  assign y_o         = y_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

@@ rtl/scan_range_to_map_point_top.sv @@
// Each accepted word goes through the angle, setup, rotate, gain and finish steps, and
// no new word is taken until it leaves finish: the 16-step CORDIC loop and the shared
//   multiplier (angle index product, then x and y gain) serve one word at a time.
// The output register lets the next word in while a result waits to be taken.
// Reset (rst_ni low, asynchronous): registers take their reset values, the sample
//   counter clears, the sequencer idles and no result is pending.
`default_nettype none

module scan_range_to_map_point_top import srmp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // range sample channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [RANGE_W-1:0]    range_sample_i,
  input  logic                  last_sample_i,
  // map point channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [POS_W-1:0] point_x_o,
  output logic signed [POS_W-1:0] point_y_o,
  output logic                  last_point_o
);

  // Configuration registers
  logic signed [POS_W-1:0] pos_x_q, pos_y_q;
  logic [ANG_W-1:0]        heading_q, angle_start_q, angle_step_q;
  logic [SCNT_W-1:0]       sample_count_q;

  // Scan state
  logic [SEEN_W-1:0]       seen_q, seen_d;

  // Sequencer
  srmp_state_e             state_q, state_d;

  // Per-word working registers
  logic [RANGE_W-1:0]      range_q;
  logic                    last_q;
  logic [ANGLE_BITS-1:0]   idx_q;
  logic [1:0]              quad_q;
  logic signed [P_W-1:0]   mul_q;
  logic signed [C_W-1:0]   c_q;

  // Output register
  logic                    out_valid_q, out_valid_d;
  logic signed [POS_W-1:0] point_x_q, point_y_q;
  logic                    last_point_q;

  // Datapath
  logic                    in_fire, out_load;
  logic [ANGLE_BITS-1:0]   idx_now, ang;
  logic signed [X_W-1:0]   x0;
  logic signed [Z_W-1:0]   z0;
  logic signed [X_W-1:0]   cx, cy;
  srmp_cordic_stat_t       cordic_stat;
  logic signed [X_W-1:0]   mul_a;
  logic signed [GB_W-1:0]  mul_b;
  logic signed [P_W-1:0]   mul_p, rnd;
  logic signed [C_W-1:0]   s_now;
  logic signed [POS_W:0]   c_ext, s_ext, rot_x, rot_y, sum_x, sum_y;
  logic signed [POS_W-1:0] sat_x, sat_y;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;

  // Index of this sample within the scan; the first sample takes the highest index.
  assign idx_now = ANGLE_BITS'(sample_count_q) - ANGLE_BITS'(1) - ANGLE_BITS'(seen_q);

  // Scan angle, wrapping in binary angle units
  assign ang = ANGLE_BITS'(heading_q) - ANG_QUARTER + ANGLE_BITS'(angle_start_q)
             + mul_q[ANGLE_BITS-1:0];

  // Residual phase below a quarter turn, scaled to 2^-32 turn
  assign z0 = {2'b00, ang[ANGLE_BITS-3:0], PHASE_PAD'(0)};
  assign x0 = $signed(X_W'(range_q) * X_W'(X_SCALE));

  srmp_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == ST_SETUP),
    .x0_i   (x0),
    .z0_i   (z0),
    .x_o    (cx),
    .y_o    (cy),
    .stat_o (cordic_stat)
  );

  // Shared multiplier: index times step, then the CORDIC gain on x and on y
  always_comb begin
    mul_a = $signed(X_W'(idx_q));
    mul_b = $signed(GB_W'(angle_step_q));
    case (state_q)
      ST_GAIN_X: begin
        mul_a = cx;
        mul_b = GB_W'(GAIN_Q24);
      end
      ST_GAIN_Y: begin
        mul_a = cy;
        mul_b = GB_W'(GAIN_Q24);
      end
      default: begin
        mul_a = $signed(X_W'(idx_q));
        mul_b = $signed(GB_W'(angle_step_q));
      end
    endcase
  end

  assign mul_p = P_W'(mul_a) * P_W'(mul_b);

  // Round to nearest, ties up, then drop the 32 fraction bits
  assign rnd   = mul_q + $signed(P_W'(64'h8000_0000));
  assign s_now = rnd[P_W-1:32];

  // Exact quarter-turn rotation and offset by the robot position
  always_comb begin
    c_ext = (POS_W+1)'(c_q);
    s_ext = (POS_W+1)'(s_now);
    case (quad_q)
      2'd1: begin
        rot_x = -s_ext;
        rot_y = c_ext;
      end
      2'd2: begin
        rot_x = -c_ext;
        rot_y = -s_ext;
      end
      2'd3: begin
        rot_x = s_ext;
        rot_y = -c_ext;
      end
      default: begin
        rot_x = c_ext;
        rot_y = s_ext;
      end
    endcase
    sum_x = (POS_W+1)'(pos_x_q) + rot_x;
    sum_y = (POS_W+1)'(pos_y_q) + rot_y;
    // clamp to the signed 32-bit range
    if (sum_x[POS_W] != sum_x[POS_W-1]) begin
      sat_x = sum_x[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      sat_x = sum_x[POS_W-1:0];
    end
    if (sum_y[POS_W] != sum_y[POS_W-1]) begin
      sat_y = sum_y[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      sat_y = sum_y[POS_W-1:0];
    end
  end

  // Load the result once the output register is free
  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_ANGLE;
          // advance the sample counter, wrap at a full scan, clear after the last one
          if (last_sample_i || (seen_q == SEEN_W'(MAX_SAMPLES - 1))) begin
            seen_d = '0;
          end else begin
            seen_d = seen_q + SEEN_W'(1);
          end
        end
      end
      ST_ANGLE:  state_d = ST_SETUP;
      ST_SETUP:  state_d = ST_ROTATE;
      ST_ROTATE: begin
        if (cordic_stat.done) begin
          state_d = ST_GAIN_X;
        end
      end
      ST_GAIN_X: state_d = ST_GAIN_Y;
      ST_GAIN_Y: state_d = ST_FINISH;
      ST_FINISH: begin
        // hold until the previous word has been taken
        if (out_load) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q        <= '0;
      pos_y_q        <= '0;
      heading_q      <= '0;
      angle_start_q  <= '0;
      angle_step_q   <= '0;
      sample_count_q <= SCNT_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_POS_X:        pos_x_q        <= cfg_data_i[POS_W-1:0];
        CFG_POS_Y:        pos_y_q        <= cfg_data_i[POS_W-1:0];
        CFG_HEADING:      heading_q      <= cfg_data_i[ANG_W-1:0];
        CFG_ANGLE_START:  angle_start_q  <= cfg_data_i[ANG_W-1:0];
        CFG_ANGLE_STEP:   angle_step_q   <= cfg_data_i[ANG_W-1:0];
        CFG_SAMPLE_COUNT: sample_count_q <= cfg_data_i[SCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Working payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      range_q <= range_sample_i;
      last_q  <= last_sample_i;
      idx_q   <= idx_now;
    end
    if (state_q == ST_SETUP) begin
      quad_q <= ang[ANGLE_BITS-1:ANGLE_BITS-2];
    end
    if (state_q == ST_ANGLE || state_q == ST_GAIN_X || state_q == ST_GAIN_Y) begin
      mul_q <= mul_p;
    end
    if (state_q == ST_GAIN_Y) begin
      c_q <= s_now;
    end
    if (out_load) begin
      point_x_q    <= sat_x;
      point_y_q    <= sat_y;
      last_point_q <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign point_x_o    = point_x_q;
  assign point_y_o    = point_y_q;
  assign last_point_o = last_point_q;

  // Assertions
  a_ready_cordic_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cordic_stat.busy)
    else $error("input ready while the CORDIC loop is busy");

  a_one_word_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input ready right after an accepted word");

  a_done_in_rotate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_stat.done |-> (state_q == ST_ROTATE))
    else $error("CORDIC finished outside the rotate step");

  a_last_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_sample_i) |=> (seen_q == '0))
    else $error("sample counter not cleared after the last sample");

endmodule

`default_nettype wire

@@ tb/sv/scan_point_checker.sv @@
module scan_point_checker import srmp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [RANGE_W-1:0]    range_sample_i,
  input  logic                  last_sample_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic signed [POS_W-1:0] point_x_i,
  input  logic signed [POS_W-1:0] point_y_i,
  input  logic                  last_point_i,
  output int                    mismatches_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    last;
  } map_point_t;

  typedef enum logic [1:0] {
    QUAD_FIRST,
    QUAD_SECOND,
    QUAD_THIRD,
    QUAD_FOURTH
  } quadrant_e;

  localparam longint GAIN_SCALE = 64'sd10187995;

  // atan(2^-k), 2^-32 turn units
  longint atan_turn [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  logic signed [POS_W-1:0] robot_x;
  logic signed [POS_W-1:0] robot_y;
  logic [ANG_W-1:0]        robot_heading;
  logic [ANG_W-1:0]        scan_start;
  logic [ANG_W-1:0]        scan_step;
  logic [SCNT_W-1:0]       scan_count;
  int                      scan_seen;
  map_point_t              expected_points [$];

  function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[POS_W-1:0];
  endfunction

  function automatic map_point_t predict_point(input logic [RANGE_W-1:0] rng,
                                               input logic last);
    logic [ANGLE_BITS-1:0] idx;
    logic [ANGLE_BITS-1:0] ang;
    logic [31:0]           phase;
    quadrant_e             quad;
    longint                x, y, z, dx, dy, c, s, t;
    map_point_t            pt;
    idx   = ANGLE_BITS'(int'(scan_count) - 1 - scan_seen);
    ang   = robot_heading - ANG_QUARTER + scan_start + idx * scan_step;
    phase = {ang, {PHASE_PAD{1'b0}}};
    quad  = quadrant_e'(phase[31:30]);
    z     = longint'(phase[29:0]);
    x     = longint'(rng) * PIXELS_PER_METER * 256;
    y     = 0;
    for (int k = 0; k < 16; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_turn[k];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_turn[k];
      end
    end
    c = (x * GAIN_SCALE + (64'sd1 <<< 31)) >>> 32;
    s = (y * GAIN_SCALE + (64'sd1 <<< 31)) >>> 32;
    case (quad)
      QUAD_SECOND: begin
        t = c;
        c = -s;
        s = t;
      end
      QUAD_THIRD: begin
        c = -c;
        s = -s;
      end
      QUAD_FOURTH: begin
        t = c;
        c = s;
        s = -t;
      end
      default: ;
    endcase
    pt.x    = clamp_pos(longint'(robot_x) + c);
    pt.y    = clamp_pos(longint'(robot_y) + s);
    pt.last = last;
    return pt;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    map_point_t want;
    if (!rst_ni) begin
      robot_x       = '0;
      robot_y       = '0;
      robot_heading = '0;
      scan_start    = '0;
      scan_step     = '0;
      scan_count    = SCNT_W'(1);
      scan_seen     = 0;
      expected_points.delete();
      pending_o     = 0;
    end else begin
      // Retire the output word first: it can never belong to a word taken at this edge.
      if (out_valid_i && out_ready_i) begin
        if (expected_points.size() == 0) begin
          $error("unexpected map point: x %0d y %0d last %0b",
                 point_x_i, point_y_i, last_point_i);
          mismatches_o++;
        end else begin
          want = expected_points.pop_front();
          if (point_x_i !== want.x) begin
            $error("point_x: expected %0d, got %0d", want.x, point_x_i);
            mismatches_o++;
          end
          if (point_y_i !== want.y) begin
            $error("point_y: expected %0d, got %0d", want.y, point_y_i);
            mismatches_o++;
          end
          if (last_point_i !== want.last) begin
            $error("last_point: expected %0b, got %0b", want.last, last_point_i);
            mismatches_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_POS_X:        robot_x       = cfg_data_i[POS_W-1:0];
          CFG_POS_Y:        robot_y       = cfg_data_i[POS_W-1:0];
          CFG_HEADING:      robot_heading = cfg_data_i[ANG_W-1:0];
          CFG_ANGLE_START:  scan_start    = cfg_data_i[ANG_W-1:0];
          CFG_ANGLE_STEP:   scan_step     = cfg_data_i[ANG_W-1:0];
          CFG_SAMPLE_COUNT: scan_count    = cfg_data_i[SCNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_points.insert(expected_points.size(),
                               predict_point(range_sample_i, last_sample_i));
        if (last_sample_i) begin
          scan_seen = 0;
        end else begin
          scan_seen = scan_seen + 1;
          if (scan_seen >= MAX_SAMPLES) scan_seen = 0;
        end
      end
      pending_o = expected_points.size();
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top import srmp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [RANGE_W-1:0]      range_sample_i;
  logic                    last_sample_i;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [POS_W-1:0] point_x_o;
  logic signed [POS_W-1:0] point_y_o;
  logic                    last_point_o;

  int mismatch_count;
  int points_pending;
  int random_words;
  int ready_hold;
  bit calm;

  scan_range_to_map_point_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .range_sample_i (range_sample_i),
    .last_sample_i  (last_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .last_point_o   (last_point_o)
  );

  scan_point_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .range_sample_i (range_sample_i),
    .last_sample_i  (last_sample_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .point_x_i      (point_x_o),
    .point_y_i      (point_y_o),
    .last_point_i   (last_point_o),
    .mismatches_o   (mismatch_count),
    .pending_o      (points_pending)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Output side: stall at random, never starting a stall once the run turns calm.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      ready_hold--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      ready_hold = $urandom_range(1, 3) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Bias toward the range extremes so zero and full scale come up often.
  function automatic logic [RANGE_W-1:0] pick_range();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return RANGE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Robot position: mostly near the origin, sometimes anywhere or at a rail.
  function automatic logic [CFG_DATA_W-1:0] pick_pos();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom();
      default: return 32'($signed(25'($urandom())));
    endcase
  endfunction

  // Samples per scan: mostly short scans, plus zero, the full depth and the 12-bit top.
  // Upper data bits carry noise the register must drop.
  function automatic logic [CFG_DATA_W-1:0] pick_count();
    logic [CFG_DATA_W-1:0] noise;
    noise = $urandom();
    case ($urandom_range(0, 11))
      0:       return {noise[31:SCNT_W], SCNT_W'(0)};
      1:       return {noise[31:SCNT_W], SCNT_W'(4095)};
      2:       return {noise[31:SCNT_W], SCNT_W'(MAX_SAMPLES)};
      default: return {noise[31:SCNT_W], SCNT_W'($urandom_range(1, 40))};
    endcase
  endfunction

  // Hold one config word until taken; leave valid high for the next one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Write all six registers, now and then an unused index too, then drop valid.
  task automatic load_settings(input logic [CFG_DATA_W-1:0] px,
                               input logic [CFG_DATA_W-1:0] py,
                               input logic [CFG_DATA_W-1:0] hd,
                               input logic [CFG_DATA_W-1:0] start,
                               input logic [CFG_DATA_W-1:0] step,
                               input logic [CFG_DATA_W-1:0] count);
    write_reg(CFG_POS_X, px);
    write_reg(CFG_POS_Y, py);
    write_reg(CFG_HEADING, hd);
    write_reg(CFG_ANGLE_START, start);
    write_reg(CFG_ANGLE_STEP, step);
    write_reg(CFG_SAMPLE_COUNT, count);
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_SAMPLE_COUNT + CFG_IDX_W'($urandom_range(1, 2)), $urandom());
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one range word. Valid stays high after the handshake so back-to-back words
  // never lower and raise it in the same step; a gap drops it first.
  task automatic send_word(input logic [RANGE_W-1:0] rng, input logic last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    range_sample_i <= rng;
    last_sample_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_run(input int n, input bit close);
    for (int i = 0; i < n; i++) send_word(pick_range(), close && (i == n - 1));
  endtask

  // Drop valid and hold until every predicted point is out. Wait on the clock first so the
  // checker has counted the word taken at the last handshake.
  task automatic drain_points();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (points_pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int  scan_len;
    bit  close;
    logic [CFG_DATA_W-1:0] count;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    range_sample_i = '0;
    last_sample_i  = 1'b0;
    calm           = 1'b0;
    random_words   = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero range, full range, and a scan close.
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word('1, 1'b1);

    // One step per quarter turn over four samples: walk all quadrants at full range,
    // with the robot at the rails so both axes saturate.
    drain_points();
    load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'(ANG_QUARTER), '0,
                  32'(ANG_QUARTER), 32'd4);
    send_word('1, 1'b0);
    send_word('1, 1'b0);
    send_word('1, 1'b0);
    send_word('1, 1'b1);

    // All angles at their top so every sum wraps; sample count of zero.
    drain_points();
    load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF,
                  32'h0000_FFFF, 32'hFFFF_F000);
    send_word('1, 1'b0);
    send_word(pick_range(), 1'b0);
    send_word(16'h5A5A, 1'b1);

    // Sample count above the scan depth.
    drain_points();
    load_settings('0, '0, '0, 32'h0000_8000, 32'd12345, 32'd4095);
    send_run(3, 1'b1);

    // Full-depth scan setting, first samples only.
    drain_points();
    load_settings(32'd1000, -32'sd1000, 32'd100, 32'd200, 32'd1, 32'(MAX_SAMPLES));
    send_run(2, 1'b1);

    // Random part: new settings per phase, then a few scans, mostly well formed.
    while (random_words < 1385) begin
      drain_points();
      count = pick_count();
      load_settings(pick_pos(), pick_pos(), $urandom(), $urandom(), $urandom(), count);
      repeat ($urandom_range(1, 4)) begin
        scan_len = int'(count[SCNT_W-1:0]);
        if (scan_len < 1 || scan_len > 64) scan_len = $urandom_range(1, 40);
        close = 1'b1;
        // Break some scans: drop the close, or close early.
        if ($urandom_range(0, 7) == 0) begin
          if ($urandom_range(0, 1) == 1) close = 1'b0;
          else scan_len = $urandom_range(1, scan_len);
        end
        send_run(scan_len, close);
        random_words += scan_len;
        if (random_words > 1200) calm = 1'b1;
      end
    end

    // Let the pipe empty, then give late extra words time to show up.
    drain_points();
    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0 && points_pending == 0) begin
      $display("scan_range_to_map_point_top verification clean");
    end else begin
      $display("scan_range_to_map_point_top verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("scan_range_to_map_point_top verification failed");
    $finish;
  end

endmodule
